>>> hdl/dpid_pkg.sv
// shared types and constants for the dual-axis pid block
`default_nettype none
package dpid_pkg;

  localparam int ERR_WIDTH_DEF      = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int ACC_WIDTH_DEF      = 32;
  localparam int GAIN_WIDTH         = 16;
  localparam int DRIVE_WIDTH        = 32;
  localparam int PADDR_WIDTH        = 5;
  localparam int PDATA_WIDTH        = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P_X = 3'd0,
    REG_GAIN_I_X = 3'd1,
    REG_GAIN_D_X = 3'd2,
    REG_GAIN_P_Y = 3'd3,
    REG_GAIN_I_Y = 3'd4,
    REG_GAIN_D_Y = 3'd5
  } dpid_reg_t;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } dpid_op_t;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] p;
    logic signed [GAIN_WIDTH-1:0] i;
    logic signed [GAIN_WIDTH-1:0] d;
  } dpid_gain_t;

  typedef struct packed {
    logic step;
    logic clear;
  } dpid_lane_ctl_t;

endpackage
`default_nettype wire

>>> hdl/dpid_if.sv
// valid/ready channel interfaces for error samples and drive results
`default_nettype none
interface dpid_sample_if #(
  parameter int ERR_WIDTH = dpid_pkg::ERR_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic signed [ERR_WIDTH-1:0] error_x;
  logic signed [ERR_WIDTH-1:0] error_y;

  modport source (output valid, opcode, error_x, error_y, input ready);
  modport sink (input valid, opcode, error_x, error_y, output ready);
endinterface

interface dpid_drive_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dpid_pkg::DRIVE_WIDTH-1:0] drive_x;
  logic signed [dpid_pkg::DRIVE_WIDTH-1:0] drive_y;

  modport source (output valid, drive_x, drive_y, input ready);
  modport sink (input valid, drive_x, drive_y, output ready);
endinterface
`default_nettype wire

>>> hdl/dpid_regs.sv
// apb gain register file
`default_nettype none
module dpid_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dpid_pkg::PADDR_WIDTH-1:0] paddr,
  input  wire logic [dpid_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic      [dpid_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                                  pready,
  output dpid_pkg::dpid_gain_t                  gain_x,
  output dpid_pkg::dpid_gain_t                  gain_y
);
  import dpid_pkg::*;

  logic            wr_en;
  dpid_reg_t       reg_sel;
  logic [GAIN_WIDTH-1:0] wdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = dpid_reg_t'(paddr[4:2]);
  assign wdata   = pwdata[GAIN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x <= '0;
      gain_y <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_GAIN_P_X: gain_x.p <= wdata;
        REG_GAIN_I_X: gain_x.i <= wdata;
        REG_GAIN_D_X: gain_x.d <= wdata;
        REG_GAIN_P_Y: gain_y.p <= wdata;
        REG_GAIN_I_Y: gain_y.i <= wdata;
        REG_GAIN_D_Y: gain_y.d <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_GAIN_P_X: prdata[GAIN_WIDTH-1:0] = gain_x.p;
      REG_GAIN_I_X: prdata[GAIN_WIDTH-1:0] = gain_x.i;
      REG_GAIN_D_X: prdata[GAIN_WIDTH-1:0] = gain_x.d;
      REG_GAIN_P_Y: prdata[GAIN_WIDTH-1:0] = gain_y.p;
      REG_GAIN_I_Y: prdata[GAIN_WIDTH-1:0] = gain_y.i;
      REG_GAIN_D_Y: prdata[GAIN_WIDTH-1:0] = gain_y.d;
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/dpid_lane.sv
// one pid lane: integral and last-error state, product registers, sum and saturation
`default_nettype none
module dpid_lane #(
  parameter int ERR_WIDTH      = dpid_pkg::ERR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = dpid_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = dpid_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dpid_pkg::dpid_lane_ctl_t             ctl,
  input  wire logic signed [ERR_WIDTH-1:0]          err,
  input  wire dpid_pkg::dpid_gain_t                 gain,
  output logic signed [dpid_pkg::DRIVE_WIDTH-1:0]   drive
);
  import dpid_pkg::*;

  // integral add width, difference width, product widths, full sum width, clamp width
  localparam int IW  = ((ACC_WIDTH > ERR_WIDTH) ? ACC_WIDTH : ERR_WIDTH) + 1;
  localparam int DW  = ERR_WIDTH + 1;
  localparam int PPW = GAIN_WIDTH + ERR_WIDTH;
  localparam int PIW = GAIN_WIDTH + ACC_WIDTH;
  localparam int PDW = GAIN_WIDTH + DW;
  localparam int PW  = ((PIW > PDW) ? PIW : PDW) + 2;
  localparam int CW  = (PW > DRIVE_WIDTH + 1) ? PW : DRIVE_WIDTH + 1;

  localparam logic signed [IW-1:0] INT_HI = {{(IW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [IW-1:0] INT_LO = -INT_HI - IW'(1);
  localparam logic signed [CW-1:0] DRV_HI =
    {{(CW-DRIVE_WIDTH+1){1'b0}}, {(DRIVE_WIDTH-1){1'b1}}};
  localparam logic signed [CW-1:0] DRV_LO = -DRV_HI - CW'(1);

  logic signed [ACC_WIDTH-1:0] integral;
  logic signed [ACC_WIDTH-1:0] integral_next;
  logic signed [ERR_WIDTH-1:0] last_err;
  logic signed [IW-1:0]        int_sum;
  logic signed [DW-1:0]        diff;

  logic signed [PPW-1:0] prod_p, prod_p_next;
  logic signed [PIW-1:0] prod_i, prod_i_next;
  logic signed [PDW-1:0] prod_d, prod_d_next;

  logic signed [PW-1:0]  pid_sum;
  logic signed [PW-1:0]  pid_shift;
  logic signed [CW-1:0]  pid_wide;

  always_comb begin
    int_sum = IW'(integral) + IW'(err);
    if (int_sum > INT_HI) begin
      integral_next = INT_HI[ACC_WIDTH-1:0];
    end else if (int_sum < INT_LO) begin
      integral_next = INT_LO[ACC_WIDTH-1:0];
    end else begin
      integral_next = int_sum[ACC_WIDTH-1:0];
    end
    diff        = DW'(err) - DW'(last_err);
    prod_p_next = gain.p * err;
    prod_i_next = gain.i * integral_next;
    prod_d_next = gain.d * diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      last_err <= '0;
    end else if (ctl.clear) begin
      integral <= '0;
    end else if (ctl.step) begin
      integral <= integral_next;
      last_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
  end

  // floor shift then clamp to the drive range
  always_comb begin
    pid_sum   = PW'(prod_p) + PW'(prod_i) + PW'(prod_d);
    pid_shift = pid_sum >>> GAIN_FRAC_BITS;
    pid_wide  = CW'(pid_shift);
    if (pid_wide > DRV_HI) begin
      drive = DRV_HI[DRIVE_WIDTH-1:0];
    end else if (pid_wide < DRV_LO) begin
      drive = DRV_LO[DRIVE_WIDTH-1:0];
    end else begin
      drive = pid_wide[DRIVE_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hdl/dual_axis_pid.sv
// dual_axis_pid: two fixed-point pid lanes (x and y) behind valid/ready channels
//
// sample channel: one beat carries opcode, error_x, error_y. a step beat
// (opcode 0) gives one drive beat with drive_x and drive_y; a clear beat
// (opcode 1) zeroes both integrals, keeps the last errors, and gives no beat.
// gains are six q8.8 apb registers; the user must write them only while idle, unchecked.
// pipeline: sample register, product register (integral update and the three
// multiplies per axis), drive register (sum, floor shift, clamp). throughput:
// one sample per clock unless the receiver stalls; each stage holds only while
// its successor is full and stalled, so a sample is still taken while a finished
// drive waits. a stalled receiver fills the three stages, then sample ready drops.
// reset clears all gains, both integrals, both last errors and every stage
// valid bit.
`default_nettype none
module dual_axis_pid #(
  parameter int ERR_WIDTH      = dpid_pkg::ERR_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = dpid_pkg::GAIN_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = dpid_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dpid_pkg::PADDR_WIDTH-1:0] paddr,
  input  wire logic [dpid_pkg::PDATA_WIDTH-1:0] pwdata,
  output logic      [dpid_pkg::PDATA_WIDTH-1:0] prdata,
  output logic                                  pready,
  dpid_sample_if.sink                           sample,
  dpid_drive_if.source                          drive
);
  import dpid_pkg::*;

  dpid_gain_t gain_x;
  dpid_gain_t gain_y;

  logic                        s0_valid;
  logic                        s0_opcode;
  logic signed [ERR_WIDTH-1:0] s0_err_x;
  logic signed [ERR_WIDTH-1:0] s0_err_y;
  logic                        s1_valid;
  logic                        out_valid;
  logic signed [DRIVE_WIDTH-1:0] out_x;
  logic signed [DRIVE_WIDTH-1:0] out_y;
  logic signed [DRIVE_WIDTH-1:0] lane_x_drive;
  logic signed [DRIVE_WIDTH-1:0] lane_y_drive;

  logic           out_adv;
  logic           s1_adv;
  logic           s0_adv;
  dpid_lane_ctl_t lane_ctl;

  dpid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain_x  (gain_x),
    .gain_y  (gain_y)
  );

  assign out_adv = !out_valid || drive.ready;
  assign s1_adv  = !s1_valid || out_adv;
  assign s0_adv  = !s0_valid || s1_adv;

  assign sample.ready = s0_adv;

  always_comb begin
    lane_ctl.step  = s0_valid && s1_adv && (dpid_op_t'(s0_opcode) == OP_STEP);
    lane_ctl.clear = s0_valid && s1_adv && (dpid_op_t'(s0_opcode) == OP_CLEAR);
  end

  dpid_lane #(
    .ERR_WIDTH      (ERR_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .err   (s0_err_x),
    .gain  (gain_x),
    .drive (lane_x_drive)
  );

  dpid_lane #(
    .ERR_WIDTH      (ERR_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .err   (s0_err_y),
    .gain  (gain_y),
    .drive (lane_y_drive)
  );

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_adv) begin
      s0_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && sample.valid) begin
      s0_opcode <= sample.opcode;
      s0_err_x  <= sample.error_x;
      s0_err_y  <= sample.error_y;
    end
  end

  // product stage: clear beats drop out here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= lane_ctl.step;
    end
  end

  // drive register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      out_x <= lane_x_drive;
      out_y <= lane_y_drive;
    end
  end

  assign drive.valid   = out_valid;
  assign drive.drive_x = out_x;
  assign drive.drive_y = out_y;

endmodule
`default_nettype wire
